// ----- src/bls_pkg.sv -----
// Shared types and constants for the bounded LIFO stack.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package bls_pkg;

  localparam int DEPTH  = 64;
  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_POP     = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;
  localparam logic [1:0] OP_DISPLAY = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [WORD_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_word;
    logic [1:0]               status;
    logic                     is_empty;
    logic                     is_full;
    logic                     last_of_run;
  } rsp_t;

  typedef struct packed {
    logic shift_dn;
    logic shift_up;
  } cell_ctl_t;

  typedef struct packed {
    cell_ctl_t        shift;
    logic [CNT_W-1:0] bottom;
  } chain_ctl_t;

endpackage

// ----- src/bls_cell.sv -----
// One storage cell of the stack chain: holds one word and moves it to a neighbor.
// Depends on bls_pkg.
`timescale 1ns / 1ps

module bls_cell (
  input  logic                              clk,
  input  bls_pkg::cell_ctl_t                ctl,
  input  logic                              wrap,
  input  logic signed [bls_pkg::WORD_W-1:0] from_above,
  input  logic signed [bls_pkg::WORD_W-1:0] from_below,
  input  logic signed [bls_pkg::WORD_W-1:0] wrap_word,
  output logic signed [bls_pkg::WORD_W-1:0] word
);
  import bls_pkg::*;

  // The bottom cell of the occupied region takes the top word when shifting up,
  // which turns a shift into a rotation during a display run.
  always_ff @(posedge clk) begin
    if (ctl.shift_dn) begin
      word <= from_above;
    end else if (ctl.shift_up) begin
      word <= wrap ? wrap_word : from_below;
    end
  end

endmodule

// ----- src/bls_ctrl.sv -----
// Controller of the stack: fill count, display sequencing and response register.
// Depends on bls_pkg.
`timescale 1ns / 1ps

module bls_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  bls_pkg::cmd_t                     cmd,
  input  logic signed [bls_pkg::WORD_W-1:0] top_word,
  output bls_pkg::chain_ctl_t               chain,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output bls_pkg::rsp_t                     rsp
);
  import bls_pkg::*;

  typedef enum logic {S_RUN, S_SHOW} state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] remain, remain_next;
  logic             rsp_valid_next;
  rsp_t             rsp_next;
  logic             slot_free;
  logic             take;
  logic             show_step;
  logic             produce;
  cell_ctl_t        cell_ctl;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign cmd_stall = (state != S_RUN) || !slot_free;
  assign take      = cmd_valid && !cmd_stall;
  assign show_step = (state == S_SHOW) && slot_free;
  assign produce   = take || show_step;

  always_comb begin
    state_next           = state;
    count_next           = count;
    remain_next          = remain;
    cell_ctl             = '0;
    rsp_next             = rsp;
    rsp_next.data_word   = '0;
    rsp_next.status      = ST_OK;
    rsp_next.last_of_run = 1'b1;
    if (take) begin
      case (cmd.opcode)
        OP_PUSH: begin
          if (count == CNT_W'(DEPTH)) begin
            rsp_next.status = ST_OVERFLOW;
          end else begin
            cell_ctl.shift_dn  = 1'b1;
            count_next         = count + 1'b1;
            rsp_next.data_word = cmd.push_value;
          end
        end
        OP_POP: begin
          if (count == '0) begin
            rsp_next.status = ST_EMPTY;
          end else begin
            cell_ctl.shift_up  = 1'b1;
            count_next         = count - 1'b1;
            rsp_next.data_word = top_word;
          end
        end
        OP_PEEK: begin
          if (count == '0) begin
            rsp_next.status = ST_EMPTY;
          end else begin
            rsp_next.data_word = top_word;
          end
        end
        OP_DISPLAY: begin
          if (count == '0) begin
            rsp_next.status = ST_EMPTY;
          end else begin
            cell_ctl.shift_up    = 1'b1;
            rsp_next.data_word   = top_word;
            remain_next          = count - 1'b1;
            rsp_next.last_of_run = (count == CNT_W'(1));
            if (count != CNT_W'(1)) begin
              state_next = S_SHOW;
            end
          end
        end
        default: begin
          rsp_next.status = ST_EMPTY;
        end
      endcase
    end else if (show_step) begin
      cell_ctl.shift_up    = 1'b1;
      rsp_next.data_word   = top_word;
      remain_next          = remain - 1'b1;
      rsp_next.last_of_run = (remain == CNT_W'(1));
      if (remain == CNT_W'(1)) begin
        state_next = S_RUN;
      end
    end
    rsp_next.is_empty = (count_next == '0);
    rsp_next.is_full  = (count_next == CNT_W'(DEPTH));

    if (produce) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  assign chain.shift  = cell_ctl;
  assign chain.bottom = count - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      count     <= '0;
      remain    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remain    <= remain_next;
      rsp_valid <= rsp_valid_next;
    end
    if (produce) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- src/bounded_lifo_stack_top.sv -----
// Top level of the bounded LIFO stack: a chain of word cells and its controller.
// Depends on bls_pkg, bls_cell and bls_ctrl.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+--------------------------------------------
//   cmd     | cmd_valid / cmd_stall | opcode, push_value
//   rsp     | rsp_valid / rsp_stall | data_word, status, is_empty, is_full, last
//
// Push, pop and peek may follow one another every cycle unless cmd_stall is high.
// Display of N entries gives N responses by rotating the cell chain;
// cmd_stall stays high until its last response has been registered.
// Reset clears the fill count, the display state and the response valid flag;
// cell contents are kept.
// A stalled response holds the response register, which then stalls cmd.
`timescale 1ns / 1ps

module bounded_lifo_stack_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  bls_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bls_pkg::rsp_t rsp
);
  import bls_pkg::*;

  logic signed [WORD_W-1:0] words [DEPTH];
  chain_ctl_t               chain;

  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .top_word  (words[0]),
    .chain     (chain),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] above;
    logic signed [WORD_W-1:0] below;

    if (i == 0) begin : g_first
      assign above = cmd.push_value;
    end else begin : g_mid_above
      assign above = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign below = words[0];
    end else begin : g_mid_below
      assign below = words[i+1];
    end

    bls_cell u_cell (
      .clk        (clk),
      .ctl        (chain.shift),
      .wrap       (chain.bottom == CNT_W'(i)),
      .from_above (above),
      .from_below (below),
      .wrap_word  (words[0]),
      .word       (words[i])
    );
  end

endmodule

// ----- src/bls_checker.sv -----
// Port-level checks for the bounded LIFO stack, bound to the top level.
// Depends on bls_pkg and bounded_lifo_stack_top.
`timescale 1ns / 1ps

module bls_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input bls_pkg::cmd_t cmd,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input bls_pkg::rsp_t rsp
);
  import bls_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("Response valid right after reset.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("Stalled response changed.");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.is_empty && rsp.is_full))
    else $error("Stack reported empty and full at once.");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_OVERFLOW |-> rsp.is_full && rsp.last_of_run)
    else $error("Overflow reported on a stack that is not full.");

  a_single: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && cmd.opcode != OP_DISPLAY
      |=> rsp_valid && rsp.last_of_run)
    else $error("Single-result request gave no final response.");

endmodule

bind bounded_lifo_stack_top bls_checker u_bls_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
